### rtl/ssi_pkg.sv
// shared types and constants for the segment intersection core
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

	// kind of each result item
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_CROSS = 2'd1,
		KIND_COLL  = 2'd2
	} kind_t;

	// at most this many points per input item
	localparam int MAX_PTS = 4;

endpackage

`default_nettype wire

### rtl/ssi_if.sv
// valid/ready channel interfaces for segment pairs and intersection points
`timescale 1ns / 1ps
`default_nettype none

interface ssi_seg_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic signed [W-1:0] seg1_start_x;
	logic signed [W-1:0] seg1_start_y;
	logic signed [W-1:0] seg1_end_x;
	logic signed [W-1:0] seg1_end_y;
	logic signed [W-1:0] seg2_start_x;
	logic signed [W-1:0] seg2_start_y;
	logic signed [W-1:0] seg2_end_x;
	logic signed [W-1:0] seg2_end_y;

	modport source (output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
		seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, input ready);
	modport sink (input valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
		seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, output ready);
endinterface

interface ssi_pt_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic signed [W-1:0] point_x;
	logic signed [W-1:0] point_y;
	logic found;
	logic [1:0] kind;
	logic last_of_run;

	modport source (output valid, point_x, point_y, found, kind, last_of_run, input ready);
	modport sink (input valid, point_x, point_y, found, kind, last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/ssi_divider.sv
// pipelined restoring divider, one quotient bit per stage, two numerators share a divisor
`timescale 1ns / 1ps
`default_nettype none

module ssi_divider #(
	parameter int QW = 16,
	parameter int DW = 33,
	parameter int NW = 49,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_v,
	input  wire logic [NW-1:0] num_x,
	input  wire logic [NW-1:0] num_y,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_i,
	output logic               out_v,
	output logic [QW-1:0]      quo_x,
	output logic [QW-1:0]      quo_y,
	output logic [SW-1:0]      side_o
);

	logic          v_q  [QW];
	logic [NW-1:0] rx_q [QW];
	logic [NW-1:0] ry_q [QW];
	logic [DW-1:0] d_q  [QW];
	logic [QW-1:0] qx_q [QW];
	logic [QW-1:0] qy_q [QW];
	logic [SW-1:0] sd_q [QW];

	logic          pv  [QW];
	logic [NW-1:0] prx [QW];
	logic [NW-1:0] pry [QW];
	logic [DW-1:0] pd  [QW];
	logic [QW-1:0] pqx [QW];
	logic [QW-1:0] pqy [QW];
	logic [SW-1:0] psd [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int SH = QW - 1 - i;
		logic [NW-1:0] sh;
		logic [NW:0]   tx, ty;

		// stage inputs: first stage takes the new item
		if (i == 0) begin : g_first
			assign pv[i]  = in_v;
			assign prx[i] = num_x;
			assign pry[i] = num_y;
			assign pd[i]  = den;
			assign pqx[i] = '0;
			assign pqy[i] = '0;
			assign psd[i] = side_i;
		end else begin : g_next
			assign pv[i]  = v_q[i-1];
			assign prx[i] = rx_q[i-1];
			assign pry[i] = ry_q[i-1];
			assign pd[i]  = d_q[i-1];
			assign pqx[i] = qx_q[i-1];
			assign pqy[i] = qy_q[i-1];
			assign psd[i] = sd_q[i-1];
		end

		// trial subtract of the shifted divisor
		assign sh = NW'(pd[i]) << SH;
		assign tx = {1'b0, prx[i]} - {1'b0, sh};
		assign ty = {1'b0, pry[i]} - {1'b0, sh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= pv[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_q[i] <= tx[NW] ? prx[i] : tx[NW-1:0];
				ry_q[i] <= ty[NW] ? pry[i] : ty[NW-1:0];
				qx_q[i] <= (pqx[i] << 1) | QW'(!tx[NW]);
				qy_q[i] <= (pqy[i] << 1) | QW'(!ty[NW]);
				d_q[i]  <= pd[i];
				sd_q[i] <= psd[i];
			end
		end
	end

	assign out_v  = v_q[QW-1];
	assign quo_x  = qx_q[QW-1];
	assign quo_y  = qy_q[QW-1];
	assign side_o = sd_q[QW-1];

endmodule

`default_nettype wire

### rtl/segment_segment_intersection_core.sv
// intersection of two 2d segments, pipelined, with a run of up to four points per item
//
//  channel  dir  handshake     payload
//  seg      in   valid/ready   two segments, start and end x/y of each
//  pt       out  valid/ready   point_x, point_y, found, kind, last_of_run
//
// one item enters per cycle unless pt stalls; the output register loads from the divider
// the divider (one quotient bit per stage) sets the depth of the pipeline
// collinear overlaps give up to four results, one per ready cycle, stalling the pipe meanwhile
// all stages advance together; a stall at pt holds every stage, nothing is lost
// reset clears valid bits and the output run only
`timescale 1ns / 1ps
`default_nettype none

module segment_segment_intersection_core #(
	parameter int COORD_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	ssi_seg_if.sink  seg,
	ssi_pt_if.source pt
);

	localparam int W  = COORD_WIDTH;
	localparam int D  = W + 1;
	localparam int P  = 2 * W + 2;
	localparam int C  = 2 * W + 3;
	localparam int M  = 2 * W + 1;
	localparam int NW = 3 * W + 1;

	typedef struct packed {
		logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
		logic [3:0] wmask;
	} pts_t;

	typedef struct packed {
		pts_t pts;
		logic crossing;
		logic coll;
		logic negx;
		logic negy;
	} fin_t;

	logic en;

	// stage 1: differences and range tests
	logic              v_s1;
	pts_t              pts_s1;
	logic              degen_s1;
	logic signed [D-1:0] rx_s1, ry_s1, sx_s1, sy_s1, qx_s1, qy_s1;

	function automatic logic in_span(logic signed [W-1:0] a, logic signed [W-1:0] b,
		logic signed [W-1:0] c);
		return (a >= b && a <= c) || (a >= c && a <= b);
	endfunction

	assign seg.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s1.ax <= seg.seg1_start_x;
			pts_s1.ay <= seg.seg1_start_y;
			pts_s1.bx <= seg.seg1_end_x;
			pts_s1.by <= seg.seg1_end_y;
			pts_s1.cx <= seg.seg2_start_x;
			pts_s1.cy <= seg.seg2_start_y;
			pts_s1.dx <= seg.seg2_end_x;
			pts_s1.dy <= seg.seg2_end_y;
			pts_s1.wmask[0] <= in_span(seg.seg1_start_x, seg.seg2_start_x, seg.seg2_end_x)
				&& in_span(seg.seg1_start_y, seg.seg2_start_y, seg.seg2_end_y);
			pts_s1.wmask[1] <= in_span(seg.seg1_end_x, seg.seg2_start_x, seg.seg2_end_x)
				&& in_span(seg.seg1_end_y, seg.seg2_start_y, seg.seg2_end_y);
			pts_s1.wmask[2] <= in_span(seg.seg2_start_x, seg.seg1_start_x, seg.seg1_end_x)
				&& in_span(seg.seg2_start_y, seg.seg1_start_y, seg.seg1_end_y);
			pts_s1.wmask[3] <= in_span(seg.seg2_end_x, seg.seg1_start_x, seg.seg1_end_x)
				&& in_span(seg.seg2_end_y, seg.seg1_start_y, seg.seg1_end_y);
			degen_s1 <= (seg.seg1_start_x == seg.seg1_end_x
				&& seg.seg1_start_y == seg.seg1_end_y)
				|| (seg.seg2_start_x == seg.seg2_end_x
				&& seg.seg2_start_y == seg.seg2_end_y);
			rx_s1 <= D'(seg.seg1_end_x) - D'(seg.seg1_start_x);
			ry_s1 <= D'(seg.seg1_end_y) - D'(seg.seg1_start_y);
			sx_s1 <= D'(seg.seg2_end_x) - D'(seg.seg2_start_x);
			sy_s1 <= D'(seg.seg2_end_y) - D'(seg.seg2_start_y);
			qx_s1 <= D'(seg.seg2_start_x) - D'(seg.seg1_start_x);
			qy_s1 <= D'(seg.seg2_start_y) - D'(seg.seg1_start_y);
		end
	end

	// stage 2: the six cross products
	logic              v_s2;
	pts_t              pts_s2;
	logic              degen_s2, rxn_s2, ryn_s2;
	logic [W-1:0]      rxa_s2, rya_s2;
	logic signed [P-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [D-1:0] rxa_w, rya_w;

	assign rxa_w = rx_s1[D-1] ? -rx_s1 : rx_s1;
	assign rya_w = ry_s1[D-1] ? -ry_s1 : ry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s2   <= pts_s1;
			degen_s2 <= degen_s1;
			rxn_s2   <= rx_s1[D-1];
			ryn_s2   <= ry_s1[D-1];
			rxa_s2   <= W'(rxa_w);
			rya_s2   <= W'(rya_w);
			p0_s2    <= P'(rx_s1) * P'(sy_s1);
			p1_s2    <= P'(ry_s1) * P'(sx_s1);
			p2_s2    <= P'(qx_s1) * P'(ry_s1);
			p3_s2    <= P'(qy_s1) * P'(rx_s1);
			p4_s2    <= P'(qx_s1) * P'(sy_s1);
			p5_s2    <= P'(qy_s1) * P'(sx_s1);
		end
	end

	// stage 3: denominator and the two numerators
	logic              v_s3;
	pts_t              pts_s3;
	logic              degen_s3, rxn_s3, ryn_s3;
	logic [W-1:0]      rxa_s3, rya_s3;
	logic signed [C-1:0] den_s3, un_s3, tn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s3   <= pts_s2;
			degen_s3 <= degen_s2;
			rxn_s3   <= rxn_s2;
			ryn_s3   <= ryn_s2;
			rxa_s3   <= rxa_s2;
			rya_s3   <= rya_s2;
			den_s3   <= C'(p0_s2) - C'(p1_s2);
			un_s3    <= C'(p2_s2) - C'(p3_s2);
			tn_s3    <= C'(p4_s2) - C'(p5_s2);
		end
	end

	// stage 4: classify by sign and magnitude
	logic              v_s4;
	pts_t              pts_s4;
	logic              cross_s4, coll_s4, negx_s4, negy_s4;
	logic [W-1:0]      rxa_s4, rya_s4;
	logic [M-1:0]      tnm_s4, denm_s4;
	logic signed [C-1:0] dena_w, una_w, tna_w;
	logic              denz_w, unz_w, tok_w, uok_w, base_w;

	assign dena_w = den_s3[C-1] ? -den_s3 : den_s3;
	assign una_w  = un_s3[C-1] ? -un_s3 : un_s3;
	assign tna_w  = tn_s3[C-1] ? -tn_s3 : tn_s3;
	assign denz_w = den_s3 == '0;
	assign unz_w  = un_s3 == '0;
	assign tok_w  = (tn_s3 == '0) || ((tn_s3[C-1] == den_s3[C-1]) && (tna_w <= dena_w));
	assign uok_w  = unz_w || ((un_s3[C-1] == den_s3[C-1]) && (una_w <= dena_w));
	assign base_w = tn_s3[C-1] != den_s3[C-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s4   <= pts_s3;
			cross_s4 <= !degen_s3 && !denz_w && tok_w && uok_w;
			coll_s4  <= !degen_s3 && denz_w && unz_w;
			negx_s4  <= base_w ^ rxn_s3;
			negy_s4  <= base_w ^ ryn_s3;
			rxa_s4   <= rxa_s3;
			rya_s4   <= rya_s3;
			tnm_s4   <= M'(tna_w);
			denm_s4  <= M'(dena_w);
		end
	end

	// stage 5: partial products of |tn| * |r|
	logic              v_s5;
	fin_t              fin_s5;
	logic [M-1:0]      denm_s5;
	logic [2*W:0]      lox_s5, loy_s5;
	logic [2*W-1:0]    hix_s5, hiy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s5.pts      <= pts_s4;
			fin_s5.crossing <= cross_s4;
			fin_s5.coll     <= coll_s4;
			fin_s5.negx     <= negx_s4;
			fin_s5.negy     <= negy_s4;
			denm_s5         <= denm_s4;
			lox_s5          <= (2*W+1)'(tnm_s4[W:0]) * (2*W+1)'(rxa_s4);
			loy_s5          <= (2*W+1)'(tnm_s4[W:0]) * (2*W+1)'(rya_s4);
			hix_s5          <= (2*W)'(tnm_s4[M-1:W+1]) * (2*W)'(rxa_s4);
			hiy_s5          <= (2*W)'(tnm_s4[M-1:W+1]) * (2*W)'(rya_s4);
		end
	end

	// stage 6: sum of the partial products
	logic              v_s6;
	fin_t              fin_s6;
	logic [M-1:0]      denm_s6;
	logic [NW-1:0]     hx_s6, hy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s6  <= fin_s5;
			denm_s6 <= denm_s5;
			hx_s6   <= NW'(lox_s5) + (NW'(hix_s5) << (W + 1));
			hy_s6   <= NW'(loy_s5) + (NW'(hiy_s5) << (W + 1));
		end
	end

	// offset along segment 1, one quotient bit per stage
	logic                 dv;
	logic [W-1:0]         ox, oy;
	logic [$bits(fin_t)-1:0] dside;
	fin_t                 f;

	ssi_divider #(
		.QW(W),
		.DW(M),
		.NW(NW),
		.SW($bits(fin_t))
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s6),
		.num_x  (hx_s6),
		.num_y  (hy_s6),
		.den    (denm_s6),
		.side_i (fin_s6),
		.out_v  (dv),
		.quo_x  (ox),
		.quo_y  (oy),
		.side_o (dside)
	);

	assign f = fin_t'(dside);

	// build the run of points for the finished item
	logic signed [W-1:0] px_w, py_w;
	logic [3:0]          nmask;
	ssi_pkg::kind_t      nkind;
	logic signed [W-1:0] nx [ssi_pkg::MAX_PTS];
	logic signed [W-1:0] ny [ssi_pkg::MAX_PTS];

	assign px_w = f.negx ? f.pts.ax - W'(ox) : f.pts.ax + W'(ox);
	assign py_w = f.negy ? f.pts.ay - W'(oy) : f.pts.ay + W'(oy);

	always_comb begin
		nmask = 4'b0001;
		nkind = ssi_pkg::KIND_NONE;
		for (int k = 0; k < ssi_pkg::MAX_PTS; k++) begin
			nx[k] = '0;
			ny[k] = '0;
		end
		if (f.coll && f.pts.wmask != 4'b0000) begin
			nmask = f.pts.wmask;
			nkind = ssi_pkg::KIND_COLL;
			nx[0] = f.pts.ax;
			ny[0] = f.pts.ay;
			nx[1] = f.pts.bx;
			ny[1] = f.pts.by;
			nx[2] = f.pts.cx;
			ny[2] = f.pts.cy;
			nx[3] = f.pts.dx;
			ny[3] = f.pts.dy;
		end else if (f.crossing) begin
			nkind = ssi_pkg::KIND_CROSS;
			nx[0] = px_w;
			ny[0] = py_w;
		end
	end

	// output register holding the run, one result a cycle while pt is ready
	logic                hold_v_q;
	logic [3:0]          mask_q;
	ssi_pkg::kind_t      kind_q;
	logic signed [W-1:0] hx_q [ssi_pkg::MAX_PTS];
	logic signed [W-1:0] hy_q [ssi_pkg::MAX_PTS];
	logic [3:0]          rest;
	logic                last;
	logic [1:0]          idx;

	assign rest = mask_q & (mask_q - 4'd1);
	assign last = rest == 4'b0000;
	assign en   = !hold_v_q || (pt.ready && last);

	always_comb begin
		if (mask_q[0]) begin
			idx = 2'd0;
		end else if (mask_q[1]) begin
			idx = 2'd1;
		end else if (mask_q[2]) begin
			idx = 2'd2;
		end else begin
			idx = 2'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			mask_q   <= 4'b0000;
		end else if (en) begin
			hold_v_q <= dv;
			mask_q   <= nmask;
		end else if (pt.ready) begin
			mask_q   <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= nkind;
			for (int k = 0; k < ssi_pkg::MAX_PTS; k++) begin
				hx_q[k] <= nx[k];
				hy_q[k] <= ny[k];
			end
		end
	end

	assign pt.valid       = hold_v_q;
	assign pt.point_x     = hx_q[idx];
	assign pt.point_y     = hy_q[idx];
	assign pt.found       = kind_q != ssi_pkg::KIND_NONE;
	assign pt.kind        = kind_q;
	assign pt.last_of_run = last;

endmodule

`default_nettype wire

### rtl/ssi_checker.sv
// port checks for the segment intersection core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ssi_checker #(
	parameter int W = 16
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         pt_valid,
	input wire logic         pt_ready,
	input wire logic [W-1:0] pt_x,
	input wire logic [W-1:0] pt_y,
	input wire logic         pt_found,
	input wire logic [1:0]   pt_kind,
	input wire logic         pt_last
);

	// found follows the kind
	a_found_kind: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid |-> (pt_found == (pt_kind != ssi_pkg::KIND_NONE)))
		else $error("found disagrees with kind");

	// a no-point result is zero and ends its run
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_found |-> pt_x == '0 && pt_y == '0 && pt_last)
		else $error("empty result not zero or not last");

	// a run continues without a gap
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_ready && !pt_last |=> pt_valid)
		else $error("run broken before its last item");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_ready |=> pt_valid && $stable(pt_x) && $stable(pt_y)
		&& $stable(pt_last))
		else $error("stalled result changed");

endmodule

bind segment_segment_intersection_core ssi_checker #(.W(COORD_WIDTH)) u_ssi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pt_valid (pt.valid),
	.pt_ready (pt.ready),
	.pt_x     (pt.point_x),
	.pt_y     (pt.point_y),
	.pt_found (pt.found),
	.pt_kind  (pt.kind),
	.pt_last  (pt.last_of_run)
);

`default_nettype wire

### dv/ssi_scoreboard.sv
// scoreboard class holding predicted intersection points for the segment core
`timescale 1ns / 1ps

class ssi_scoreboard;
	typedef struct {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic found;
		logic [1:0] kind;
		logic last;
	} point_rec_t;

	point_rec_t pending_points[$];
	int mismatches;
	int points_checked;
	int items_noted;
	int crossings_seen;
	int overlaps_seen;
	int misses_seen;

	function new();
		mismatches = 0;
		points_checked = 0;
		items_noted = 0;
		crossings_seen = 0;
		overlaps_seen = 0;
		misses_seen = 0;
	endfunction

	// a lies in the closed range spanned by b and c
	static function bit in_span(longint a, longint b, longint c);
		return (a >= b && a <= c) || (a >= c && a <= b);
	endfunction

	function void add_point(longint x, longint y, ssi_pkg::kind_t k, bit fnd);
		point_rec_t p;
		p.px = x[15:0];
		p.py = y[15:0];
		p.found = fnd;
		p.kind = k;
		p.last = 1'b0;
		pending_points = {pending_points, p};
	endfunction

	// work out the run of points for one accepted segment pair
	function void note_segments(logic signed [15:0] c[8]);
		longint ax, ay, bx, by, cx, cy, dx, dy;
		longint rx, ry, sx, sy, qx, qy;
		longint den, tn, un, hx, hy;
		int n;
		bit neg_t;
		ax = c[0]; ay = c[1]; bx = c[2]; by = c[3];
		cx = c[4]; cy = c[5]; dx = c[6]; dy = c[7];
		rx = bx - ax; ry = by - ay; sx = dx - cx; sy = dy - cy;
		qx = cx - ax; qy = cy - ay;
		n = 0;
		items_noted++;
		if (!((ax == bx && ay == by) || (cx == dx && cy == dy))) begin
			den = rx * sy - ry * sx;
			un = qx * ry - qy * rx;
			if (den == 0) begin
				// collinear: endpoints inside the other segment's box
				if (un == 0) begin
					if (in_span(ax, cx, dx) && in_span(ay, cy, dy)) begin
						add_point(ax, ay, ssi_pkg::KIND_COLL, 1); n++;
					end
					if (in_span(bx, cx, dx) && in_span(by, cy, dy)) begin
						add_point(bx, by, ssi_pkg::KIND_COLL, 1); n++;
					end
					if (in_span(cx, ax, bx) && in_span(cy, ay, by)) begin
						add_point(cx, cy, ssi_pkg::KIND_COLL, 1); n++;
					end
					if (in_span(dx, ax, bx) && in_span(dy, ay, by)) begin
						add_point(dx, dy, ssi_pkg::KIND_COLL, 1); n++;
					end
					if (n > 0) overlaps_seen++;
				end
			end else begin
				tn = qx * sy - qy * sx;
				if ((tn == 0 || ((tn < 0) == (den < 0) && (tn < 0 ? -tn : tn) <=
						(den < 0 ? -den : den))) &&
						(un == 0 || ((un < 0) == (den < 0) && (un < 0 ? -un : un) <=
						(den < 0 ? -den : den)))) begin
					// quotients truncate toward zero, as does integer division
					neg_t = (tn < 0) != (den < 0);
					hx = ((tn < 0 ? -tn : tn) * (rx < 0 ? -rx : rx)) / (den < 0 ? -den : den);
					hy = ((tn < 0 ? -tn : tn) * (ry < 0 ? -ry : ry)) / (den < 0 ? -den : den);
					add_point((neg_t != (rx < 0)) ? ax - hx : ax + hx,
						(neg_t != (ry < 0)) ? ay - hy : ay + hy, ssi_pkg::KIND_CROSS, 1);
					n++;
					crossings_seen++;
				end
			end
		end
		if (n == 0) begin
			add_point(0, 0, ssi_pkg::KIND_NONE, 0);
			misses_seen++;
		end
		pending_points[$].last = 1'b1;
	endfunction

	// compare one accepted result with the oldest prediction
	function void check_point(logic signed [15:0] x, logic signed [15:0] y, logic fnd,
			logic [1:0] k, logic lst);
		point_rec_t e;
		points_checked++;
		if (pending_points.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result x=%0d y=%0d found=%0b kind=%0d last=%0b",
					x, y, fnd, k, lst);
			return;
		end
		e = pending_points.pop_front();
		if (x !== e.px || y !== e.py || fnd !== e.found || k !== e.kind || lst !== e.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp %0d,%0d f%0b k%0d l%0b, got %0d,%0d f%0b k%0d l%0b",
					e.px, e.py, e.found, e.kind, e.last, x, y, fnd, k, lst);
		end
	endfunction
endclass

### dv/testbench.sv
// top-level testbench driving segment pairs and checking intersection points
`timescale 1ns / 1ps

module testbench;

	logic clk;
	logic arst_n;
	bit stim_done;
	ssi_scoreboard board;

	ssi_seg_if #(16) seg ();
	ssi_pt_if #(16) pt ();

	segment_segment_intersection_core #(.COORD_WIDTH(16)) dut (
		.clk(clk), .arst_n(arst_n), .seg(seg.sink), .pt(pt.source)
	);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// random coordinate, biased towards extremes and small values
	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom());
		endcase
	endfunction

	// present one segment pair and wait for acceptance
	task automatic send_pair(logic signed [15:0] c[8]);
		seg.valid <= 1'b1;
		seg.seg1_start_x <= c[0]; seg.seg1_start_y <= c[1];
		seg.seg1_end_x <= c[2]; seg.seg1_end_y <= c[3];
		seg.seg2_start_x <= c[4]; seg.seg2_start_y <= c[5];
		seg.seg2_end_x <= c[6]; seg.seg2_end_y <= c[7];
		do @(posedge clk); while (!seg.ready);
		board.note_segments(c);
	endtask

	task automatic send_gap();
		int g;
		g = $urandom_range(1, 4);
		seg.valid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	// collinear pair on a random line through a base point
	task automatic make_collinear(output logic signed [15:0] c[8]);
		int bx, by, dx, dy, t[4];
		bx = $urandom_range(0, 200) - 100;
		by = $urandom_range(0, 200) - 100;
		dx = $urandom_range(0, 6) - 3;
		dy = $urandom_range(0, 6) - 3;
		if (dx == 0 && dy == 0) dx = 1;
		foreach (t[i]) t[i] = $urandom_range(0, 10) - 5;
		c[0] = 16'(bx + dx * t[0]); c[1] = 16'(by + dy * t[0]);
		c[2] = 16'(bx + dx * t[1]); c[3] = 16'(by + dy * t[1]);
		c[4] = 16'(bx + dx * t[2]); c[5] = 16'(by + dy * t[2]);
		c[6] = 16'(bx + dx * t[3]); c[7] = 16'(by + dy * t[3]);
	endtask

	// receiver stalls on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt.ready <= 1'b0;
		end else begin
			if (pt.valid && pt.ready)
				board.check_point(pt.point_x, pt.point_y, pt.found, pt.kind, pt.last_of_run);
			pt.ready <= ($urandom_range(0, 99) < 70) || stim_done && ($urandom_range(0, 1) == 1);
		end
	end

	initial begin
		logic signed [15:0] c[8];
		logic signed [15:0] dir[25][8];
		int burst;
		board = new();
		arst_n = 1'b0;
		stim_done = 1'b0;
		seg.valid = 1'b0;
		seg.seg1_start_x = '0; seg.seg1_start_y = '0;
		seg.seg1_end_x = '0; seg.seg1_end_y = '0;
		seg.seg2_start_x = '0; seg.seg2_start_y = '0;
		seg.seg2_end_x = '0; seg.seg2_end_y = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: crossing, degenerate, parallel, collinear, extremes
		dir[0] = '{0, 0, 10, 10, 0, 10, 10, 0};
		dir[1] = '{5, 5, 5, 5, 0, 0, 1, 1};
		dir[2] = '{0, 0, 1, 1, 3, 3, 3, 3};
		dir[3] = '{0, 0, 10, 0, 0, 1, 10, 1};
		dir[4] = '{0, 0, 10, 0, 2, 0, 5, 0};
		dir[5] = '{0, 0, 10, 0, 0, 0, 10, 0};
		dir[6] = '{0, 0, 4, 0, 6, 0, 9, 0};
		dir[7] = '{0, 0, 10, 0, 10, 0, 20, 0};
		dir[8] = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768};
		dir[9] = '{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767};
		dir[10] = '{0, 0, 10, 0, 0, 0, 0, 10};
		dir[11] = '{0, 0, 10, 0, 5, 1, 5, 10};
		dir[12] = '{0, 0, 7, 3, 1, 5, 4, -6};
		dir[13] = '{-1, -1, -7, -3, -2, 0, -3, -9};
		dir[14] = '{0, 0, 3, 0, 1, -1, 2, 1};
		dir[15] = '{-32768, 0, 32767, 0, 0, -32768, 0, 32767};
		dir[16] = '{10, 0, 0, 0, 3, 0, 8, 0};
		dir[17] = '{0, 0, 10, 10, 5, 5, 15, 15};
		dir[18] = '{0, 0, 10, 0, 10, 0, 10, 5};
		dir[19] = '{-32768, -32768, -32768, 32767, -32768, 0, -32768, 5};
		dir[20] = '{1, 2, 3, 4, 5, 6, 7, 8};
		dir[21] = '{0, 0, 9, 1, 0, 1, 9, 0};
		dir[22] = '{32767, 32767, -32768, -32768, 0, 0, 1, 1};
		dir[23] = '{0, 0, 2, 2, 5, 5, 7, 7};
		dir[24] = '{0, 0, 5, 5, 10, 0, 6, 4};
		foreach (dir[i]) begin
			send_pair(dir[i]);
			if ($urandom_range(0, 3) == 0) send_gap();
		end

		// random: bursts of collinear, near-crossing and noise pairs
		for (int i = 0; i < 300; ) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst && i < 300; j++, i++) begin
				case ($urandom_range(0, 3))
					0: make_collinear(c);
					1: foreach (c[k]) c[k] = 16'($urandom_range(0, 40) - 20);
					default: foreach (c[k]) c[k] = rand_coord();
				endcase
				send_pair(c);
			end
			if ($urandom_range(0, 2) != 0) send_gap();
		end
		seg.valid <= 1'b0;
		stim_done = 1'b1;

		while (board.pending_points.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d segment pairs, %0d results checked", board.items_noted,
			board.points_checked);
		$display("crossings %0d, collinear overlaps %0d, misses %0d", board.crossings_seen,
			board.overlaps_seen, board.misses_seen);
		if (board.mismatches == 0 && board.pending_points.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end
endmodule
